FILE: rtl/page_block_allocator_macros.svh
// Assertion macros for the page block allocator
`ifndef PAGE_BLOCK_ALLOCATOR_MACROS_SVH
`define PAGE_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PBA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("page_block_allocator: assertion failed");
`define PBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("page_block_allocator: assertion failed");
`else
`define PBA_ASSERT(label, prop)
`define PBA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/pba_pkg.sv
package pba_pkg;

  localparam int unsigned PageSize  = 4096;
  localparam int unsigned MinBlock  = 4;
  localparam int unsigned SlotStep  = 2;
  localparam int unsigned LinkDepth = 4096;
  localparam int unsigned LinkAw    = $clog2(LinkDepth);
  localparam int unsigned AreaReset = 128;

  typedef struct packed {
    logic [11:0] next;
    logic [11:0] size;
  } link_t;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_REPORT = 4'b1000
  } state_e;

endpackage

FILE: rtl/pba_link_ram.sv
module pba_link_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [pba_pkg::LinkAw-1:0]  waddr_i,
  input  pba_pkg::link_t              wdata_i,
  input  logic                        re_i,
  input  logic [pba_pkg::LinkAw-1:0]  raddr_i,
  output pba_pkg::link_t              rdata_o
);

  pba_pkg::link_t mem [pba_pkg::LinkDepth];
  pba_pkg::link_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/page_block_allocator.sv
// An accepted transaction goes through EXEC and REPORT to a valid result for free, slot
// operations and allocations served from the gap; other allocations walk a non-empty free
// list in WALK, reading one block per step. A new transaction is taken only in IDLE, after
// the last result has entered the output register; a walk reads at most 4096 blocks.
// Reset: asynchronous, clears all control and page state; the link memory is not cleared.
`include "page_block_allocator_macros.svh"

module page_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [11:0] block_offset_i,
  input  logic [11:0] block_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] offset_o,
  output logic        failed_o,
  output logic [12:0] avail_bytes_o,
  output logic [11:0] fragment_bytes_o,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i
);

  pba_pkg::state_e state_q, state_d;
  pba_pkg::op_e    op_q, op_d;
  logic [11:0] ptr_q, ptr_d;
  logic [11:0] need_q, need_d;
  logic [11:0] area_q;
  logic [12:0] cell_q, cell_d;
  logic [12:0] slot_q, slot_d;
  logic [11:0] head_q, head_d;
  logic [12:0] ftotal_q, ftotal_d;
  logic [11:0] frag_q, frag_d;
  logic [11:0] cur_q, cur_d;
  logic [11:0] prev_q, prev_d;
  logic [11:0] prev_size_q, prev_size_d;
  logic [pba_pkg::LinkAw-1:0] steps_q, steps_d;
  logic [11:0] res_offset_q, res_offset_d;
  logic        res_failed_q, res_failed_d;

  logic        out_valid_q;
  logic [11:0] out_offset_q;
  logic        out_failed_q;
  logic [12:0] out_usable_q;
  logic [11:0] out_frag_q;

  logic                       ram_we;
  logic [pba_pkg::LinkAw-1:0] ram_waddr;
  pba_pkg::link_t             ram_wdata;
  logic                       ram_re;
  logic [pba_pkg::LinkAw-1:0] ram_raddr;
  pba_pkg::link_t             ram_rdata;

  logic [13:0] low;
  logic [13:0] cell_ext;
  logic [12:0] gap;
  logic [12:0] cell_after;
  logic        gap_fits;
  logic [13:0] usable_sum;
  logic [12:0] usable_sat;
  logic [13:0] ftotal_sum;
  logic [12:0] ftotal_less;
  logic [11:0] diff;
  logic        frag_en;
  logic [11:0] frag_inc;
  logic [12:0] frag_sum;
  logic        out_load;

  pba_link_ram u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign low        = {2'b00, area_q} + {1'b0, slot_q};
  assign cell_ext   = {1'b0, cell_q};
  assign gap        = (cell_ext > low) ? 13'(cell_ext - low) : '0;
  assign cell_after = cell_q - {1'b0, need_q};
  assign gap_fits   = ({1'b0, need_q} <= gap);
  assign usable_sum = {1'b0, ftotal_q} + {1'b0, gap};
  assign usable_sat = usable_sum[13] ? '1 : usable_sum[12:0];
  assign ftotal_sum = {1'b0, ftotal_q} + {2'b00, need_q};
  assign ftotal_less = (ftotal_q >= {1'b0, need_q}) ? ftotal_q - {1'b0, need_q} : '0;
  assign diff       = ram_rdata.size - need_q;
  assign frag_sum   = {1'b0, frag_q} + {1'b0, frag_inc};
  assign out_load   = (state_q == pba_pkg::ST_REPORT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    ptr_d        = ptr_q;
    need_d       = need_q;
    cell_d       = cell_q;
    slot_d       = slot_q;
    head_d       = head_q;
    ftotal_d     = ftotal_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    prev_size_d  = prev_size_q;
    steps_d      = steps_q;
    res_offset_d = res_offset_q;
    res_failed_d = res_failed_q;
    frag_en      = 1'b0;
    frag_inc     = '0;
    ram_we       = 1'b0;
    ram_waddr    = cur_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = cur_q;

    case (state_q)
      pba_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = pba_pkg::op_e'(opcode_i);
          ptr_d   = block_offset_i;
          need_d  = block_size_i;
          state_d = pba_pkg::ST_EXEC;
        end
      end
      pba_pkg::ST_EXEC: begin
        res_offset_d = '0;
        res_failed_d = 1'b0;
        state_d      = pba_pkg::ST_REPORT;
        case (op_q)
          pba_pkg::OP_ALLOC: begin
            if (gap_fits && (cell_after != '0)) begin
              cell_d       = cell_after;
              res_offset_d = cell_after[11:0];
            end else begin
              if (gap_fits) begin
                cell_d = cell_after;
              end
              cur_d   = head_q;
              prev_d  = '0;
              steps_d = '0;
              if (head_q == '0) begin
                res_failed_d = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_q;
                state_d   = pba_pkg::ST_WALK;
              end
            end
          end
          pba_pkg::OP_FREE: begin
            if (need_q < 12'(pba_pkg::MinBlock)) begin
              frag_en  = 1'b1;
              frag_inc = need_q;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = ptr_q;
              ram_wdata = '{next: head_q, size: need_q};
              head_d    = ptr_q;
            end
            ftotal_d = ftotal_sum[13] ? '1 : ftotal_sum[12:0];
          end
          pba_pkg::OP_RESERVE: begin
            if (gap >= 13'(pba_pkg::SlotStep)) begin
              slot_d = slot_q + 13'(pba_pkg::SlotStep);
            end else begin
              res_failed_d = 1'b1;
            end
          end
          pba_pkg::OP_RELEASE: begin
            if (slot_q >= 13'(pba_pkg::SlotStep)) begin
              slot_d = slot_q - 13'(pba_pkg::SlotStep);
            end
          end
          default: begin
            res_failed_d = 1'b0;
          end
        endcase
      end
      pba_pkg::ST_WALK: begin
        if (need_q <= ram_rdata.size) begin
          if (diff < 12'(pba_pkg::MinBlock)) begin
            frag_en  = 1'b1;
            frag_inc = diff;
            if (prev_q == '0) begin
              head_d = ram_rdata.next;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = prev_q;
              ram_wdata = '{next: ram_rdata.next, size: prev_size_q};
            end
          end else begin
            ram_we    = 1'b1;
            ram_waddr = cur_q;
            ram_wdata = '{next: ram_rdata.next, size: diff};
          end
          ftotal_d     = ftotal_less;
          res_offset_d = cur_q + diff;
          res_failed_d = 1'b0;
          state_d      = pba_pkg::ST_REPORT;
        end else begin
          prev_d      = cur_q;
          prev_size_d = ram_rdata.size;
          cur_d       = ram_rdata.next;
          steps_d     = steps_q + pba_pkg::LinkAw'(1);
          if ((ram_rdata.next == '0) || (steps_q == '1)) begin
            res_offset_d = '0;
            res_failed_d = 1'b1;
            state_d      = pba_pkg::ST_REPORT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ram_rdata.next;
          end
        end
      end
      pba_pkg::ST_REPORT: begin
        if (out_load) begin
          state_d = pba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pba_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    frag_d = frag_q;
    if (frag_en) begin
      frag_d = frag_sum[12] ? '1 : frag_sum[11:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pba_pkg::ST_IDLE;
      op_q         <= pba_pkg::OP_ALLOC;
      area_q       <= 12'(pba_pkg::AreaReset);
      cell_q       <= 13'(pba_pkg::PageSize);
      slot_q       <= '0;
      head_q       <= '0;
      ftotal_q     <= '0;
      frag_q       <= '0;
      cur_q        <= '0;
      prev_q       <= '0;
      prev_size_q  <= '0;
      steps_q      <= '0;
      res_offset_q <= '0;
      res_failed_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      cell_q       <= cell_d;
      slot_q       <= slot_d;
      head_q       <= head_d;
      ftotal_q     <= ftotal_d;
      frag_q       <= frag_d;
      cur_q        <= cur_d;
      prev_q       <= prev_d;
      prev_size_q  <= prev_size_d;
      steps_q      <= steps_d;
      res_offset_q <= res_offset_d;
      res_failed_q <= res_failed_d;
      if (cfg_we_i) begin
        area_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    need_q <= need_d;
    if (out_load) begin
      out_offset_q <= res_offset_q;
      out_failed_q <= res_failed_q;
      out_usable_q <= usable_sat;
      out_frag_q   <= frag_q;
    end
  end

  assign in_ready_o       = (state_q == pba_pkg::ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign offset_o         = out_offset_q;
  assign failed_o         = out_failed_q;
  assign avail_bytes_o    = out_usable_q;
  assign fragment_bytes_o = out_frag_q;

  `PBA_ASSERT(a_cell_never_grows, cell_q <= $past(cell_q))
  `PBA_ASSERT(a_frag_never_drops, frag_q >= $past(frag_q))
  `PBA_ASSERT(a_no_ram_collision, !(ram_we && ram_re && (ram_waddr == ram_raddr)))
  `PBA_ASSERT_NEXT(a_accept_starts_exec, in_valid_i && in_ready_o, state_q == pba_pkg::ST_EXEC)

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [11:0] offset;
    logic        failed;
    logic [12:0] usable;
    logic [11:0] frag;
  } space_report_t;

  class page_space_tracker;
    int unsigned     area_offset;
    int unsigned     cell_top;
    int unsigned     slot_bytes;
    int unsigned     free_head;
    int unsigned     list_bytes;
    int unsigned     frag_bytes;
    pba_pkg::link_t  links [pba_pkg::LinkDepth];
    space_report_t   space_reports [$];
    int              errors;

    function new();
      area_offset = pba_pkg::AreaReset;
      cell_top    = pba_pkg::PageSize;
      slot_bytes  = 0;
      free_head   = 0;
      list_bytes  = 0;
      frag_bytes  = 0;
      errors      = 0;
      foreach (links[i]) links[i] = '0;
    endfunction

    function int unsigned gap_bytes();
      int unsigned low;
      low = area_offset + slot_bytes;
      return (cell_top > low) ? cell_top - low : 0;
    endfunction

    function void add_fragment(int unsigned n);
      frag_bytes += n;
      if (frag_bytes > 4095) frag_bytes = 4095;
    endfunction

    function void apply_request(pba_pkg::op_e op, logic [11:0] ptr, logic [11:0] size);
      space_report_t res;
      int unsigned   addr;
      int unsigned   need;
      int unsigned   prev;
      int unsigned   cur;
      int unsigned   steps;
      int unsigned   blk;
      int unsigned   diff;
      int unsigned   usable;
      bit            found;
      res  = '0;
      addr = 32'(ptr);
      need = 32'(size);
      case (op)
        pba_pkg::OP_ALLOC: begin
          found = 1'b0;
          if (need <= gap_bytes()) begin
            cell_top -= need;
            if (cell_top != 0) begin
              res.offset = 12'(cell_top);
              found = 1'b1;
            end
          end
          if (!found) begin
            prev = 0;
            cur = free_head;
            steps = 0;
            while (cur != 0 && steps < pba_pkg::LinkDepth && !found) begin
              blk = 32'(links[cur].size);
              if (need <= blk) begin
                diff = blk - need;
                if (diff < pba_pkg::MinBlock) begin
                  add_fragment(diff);
                  if (prev == 0) free_head = 32'(links[cur].next);
                  else links[prev].next = links[cur].next;
                end else begin
                  links[cur].size = 12'(diff);
                end
                list_bytes = (list_bytes >= need) ? list_bytes - need : 0;
                res.offset = 12'(cur + diff);
                found = 1'b1;
              end else begin
                prev = cur;
                cur = 32'(links[cur].next);
                steps++;
              end
            end
            if (!found) begin
              res.offset = '0;
              res.failed = 1'b1;
            end
          end
        end
        pba_pkg::OP_FREE: begin
          if (need < pba_pkg::MinBlock) begin
            add_fragment(need);
          end else begin
            links[addr].next = 12'(free_head);
            links[addr].size = size;
            free_head = addr;
          end
          list_bytes += need;
          if (list_bytes > 8191) list_bytes = 8191;
        end
        pba_pkg::OP_RESERVE: begin
          if (gap_bytes() >= pba_pkg::SlotStep) slot_bytes += pba_pkg::SlotStep;
          else res.failed = 1'b1;
        end
        pba_pkg::OP_RELEASE: begin
          if (slot_bytes >= pba_pkg::SlotStep) slot_bytes -= pba_pkg::SlotStep;
        end
        default: ;
      endcase
      usable = list_bytes + gap_bytes();
      if (usable > 8191) usable = 8191;
      res.usable = 13'(usable);
      res.frag = 12'(frag_bytes);
      space_reports.push_back(res);
    endfunction

    function void compare_field(string name, logic [12:0] want, logic [12:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(space_report_t got);
      space_report_t want;
      if (space_reports.size() == 0) begin
        $error("unrequested result: offset %0d usable %0d", got.offset, got.usable);
        errors++;
      end else begin
        want = space_reports.pop_front();
        compare_field("offset", 13'(want.offset), 13'(got.offset));
        compare_field("failed", 13'(want.failed), 13'(got.failed));
        compare_field("avail_bytes", want.usable, got.usable);
        compare_field("fragment_bytes", 13'(want.frag), 13'(got.frag));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = '0;
  logic [11:0] block_offset_i = '0;
  logic [11:0] block_size_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [11:0] offset_o;
  logic        failed_o;
  logic [12:0] avail_bytes_o;
  logic [11:0] fragment_bytes_o;
  logic        cfg_we_i = 1'b0;
  logic [11:0] cfg_wdata_i = '0;

  page_space_tracker tracker;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  bit  offset_taken [4096];

  page_block_allocator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .block_offset_i  (block_offset_i),
    .block_size_i    (block_size_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .offset_o        (offset_o),
    .failed_o        (failed_o),
    .avail_bytes_o   (avail_bytes_o),
    .fragment_bytes_o(fragment_bytes_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_ready_i)
        tracker.check_reply({offset_o, failed_o, avail_bytes_o, fragment_bytes_o});
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o === 1'b1) ||
        (out_valid_o === 1'b1 && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(pba_pkg::op_e op, logic [11:0] ptr, logic [11:0] size);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    block_offset_i <= ptr;
    block_size_i   <= size;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    tracker.apply_request(op, ptr, size);
  endtask

  task automatic put_block(logic [11:0] ptr, logic [11:0] size);
    offset_taken[ptr] = 1'b1;
    send(pba_pkg::OP_FREE, ptr, size);
  endtask

  // wait for every transaction to report, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.space_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_area(logic [11:0] area);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= area;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.area_offset = 32'(area);
  endtask

  function automatic logic [11:0] fresh_offset();
    int unsigned v;
    do v = $urandom_range(1, 4095); while (offset_taken[v]);
    offset_taken[v] = 1'b1;
    return 12'(v);
  endfunction

  task automatic send_random();
    int          pick;
    int          r;
    logic [11:0] ptr;
    logic [11:0] size;
    pick = $urandom_range(0, 99);
    r    = $urandom_range(0, 99);
    ptr  = 12'($urandom_range(0, 4095));
    size = 12'($urandom_range(0, 4095));
    if (pick < 40) begin
      if (r < 70) size = 12'($urandom_range(0, 120));
      else if (r < 90) size = 12'($urandom_range(0, 600));
      send(pba_pkg::OP_ALLOC, ptr, size);
    end else if (pick < 80) begin
      if (r < 10) size = 12'($urandom_range(0, 3));
      else if (r < 80) size = 12'($urandom_range(4, 160));
      else if (r < 95) size = 12'($urandom_range(0, 800));
      // drop the whole list now and then to keep walks short
      if ($urandom_range(0, 49) == 0) ptr = '0;
      else ptr = fresh_offset();
      send(pba_pkg::OP_FREE, ptr, size);
    end else if (pick < 90) begin
      send(pba_pkg::OP_RESERVE, ptr, size);
    end else begin
      send(pba_pkg::OP_RELEASE, ptr, size);
    end
  endtask

  task automatic run_phase(logic [11:0] area, int idle, int stall, int count);
    set_area(area);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) send_random();
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_area(12'd128);

    send(pba_pkg::OP_RELEASE, 12'd0, 12'd0);
    send(pba_pkg::OP_RESERVE, 12'd4095, 12'd4095);
    send(pba_pkg::OP_RELEASE, 12'd0, 12'd0);
    send(pba_pkg::OP_ALLOC, 12'd0, 12'd0);
    send(pba_pkg::OP_ALLOC, 12'd0, 12'd4095);
    put_block(12'd4095, 12'd4095);
    put_block(12'd2048, 12'd3);
    send(pba_pkg::OP_ALLOC, 12'd0, 12'd4093);
    put_block(12'd100, 12'd100);
    put_block(12'd2000, 12'd4000);
    put_block(12'd3000, 12'd10);
    send(pba_pkg::OP_ALLOC, 12'd0, 12'd3990);
    send(pba_pkg::OP_ALLOC, 12'd0, 12'd4000);
    send(pba_pkg::OP_ALLOC, 12'd0, 12'd12);
    // same block twice: the list loops on itself
    put_block(12'd3000, 12'd10);
    send(pba_pkg::OP_ALLOC, 12'd0, 12'd4095);
    put_block(12'd0, 12'd50);
    send(pba_pkg::OP_ALLOC, 12'd0, 12'd4090);
    put_block(12'd1, 12'd4095);
    put_block(12'd2, 12'd4095);
    put_block(12'd3, 12'd4095);
    send(pba_pkg::OP_ALLOC, 12'd0, 12'd4095);
    send(pba_pkg::OP_ALLOC, 12'd0, 12'd4095);
    send(pba_pkg::OP_ALLOC, 12'd0, 12'd4095);

    run_phase(12'd200, 0, 0, 200);
    run_phase(12'd4095, 83, 0, 200);
    run_phase(12'($urandom_range(1, 4094)), 0, 83, 200);
    run_phase(12'd0, 35, 35, 200);

    // hold the result side off while the sender keeps offering
    settle();
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    repeat (50) send_random();

    // run the gap down to offset zero
    settle();
    while (tracker.slot_bytes != 0) send(pba_pkg::OP_RELEASE, 12'd0, 12'd0);
    if (tracker.cell_top > 1) send(pba_pkg::OP_ALLOC, 12'd0, 12'(tracker.cell_top - 1));
    send(pba_pkg::OP_ALLOC, 12'd0, 12'(tracker.cell_top));

    settle();
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
